// ----- rtl/cic_charge_deposit_2d_core_defines.svh -----
// ----------------------------------------------------------------------------
// cic_charge_deposit_2d_core_defines.svh
// Assertion macros shared by the charge deposition core.
// ----------------------------------------------------------------------------
`ifndef CIC_CHARGE_DEPOSIT_2D_CORE_DEFINES_SVH
`define CIC_CHARGE_DEPOSIT_2D_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define CCD2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCD2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ccd2d_pkg.sv -----
// ----------------------------------------------------------------------------
// ccd2d_pkg
// Constants and types of the 2D cloud-in-cell charge deposition core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ccd2d_pkg;

  localparam int MAX_NODES_X = 64;
  localparam int MAX_NODES_Y = 64;
  localparam int X_BITS      = $clog2(MAX_NODES_X);
  localparam int Y_BITS      = $clog2(MAX_NODES_Y);
  localparam int ADDR_BITS   = X_BITS + Y_BITS;
  localparam int DEPTH       = MAX_NODES_X * MAX_NODES_Y;
  localparam int EXT_BITS    = 7;
  localparam int MOD_STEPS   = 31;
  localparam int MOD_CNT_BITS = $clog2(MOD_STEPS + 1);

  localparam logic [1:0] CMD_DEPOSIT = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [2:0] REG_NX     = 3'd0;
  localparam logic [2:0] REG_NY     = 3'd1;
  localparam logic [2:0] REG_PER    = 3'd2;
  localparam logic [2:0] REG_INVX   = 3'd3;
  localparam logic [2:0] REG_INVY   = 3'd4;
  localparam logic [2:0] REG_SCALE  = 3'd5;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [31:0]          wdata;
    logic [ADDR_BITS-1:0] raddr;
  } ram_req_t;

endpackage

// ----- rtl/ccd2d_if.sv -----
// ----------------------------------------------------------------------------
// ccd2d_if
// Valid/ready channels for command words and read-back words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface ccd2d_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic               alive;
  logic [5:0]         node_x;
  logic [5:0]         node_y;
  modport source (output valid, command, pos_x, pos_y, alive, node_x, node_y,
                  input ready);
  modport sink (input valid, command, pos_x, pos_y, alive, node_x, node_y,
                output ready);
endinterface

interface ccd2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] node_charge;
  modport source (output valid, node_charge, input ready);
  modport sink (input valid, node_charge, output ready);
endinterface

// ----- rtl/ccd2d_grid_ram.sv -----
// ----------------------------------------------------------------------------
// ccd2d_grid_ram
// Density grid memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ccd2d_grid_ram
  import ccd2d_pkg::*;
(
  input  logic        clk,
  input  ram_req_t    req,
  output logic [31:0] rdata
);
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- rtl/ccd2d_axis_mod.sv -----
// ----------------------------------------------------------------------------
// ccd2d_axis_mod
// Bit-serial remainder of a 31-bit value by a node count, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ccd2d_axis_mod
  import ccd2d_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [MOD_STEPS-1:0] dividend,
  input  logic [EXT_BITS-1:0] divisor,
  output logic [EXT_BITS-2:0] rem,
  output logic                done
);
  logic [MOD_STEPS-1:0]    sh_r;
  logic [EXT_BITS-1:0]     rem_r, rem_nxt;
  logic [MOD_CNT_BITS-1:0] cnt_r;
  logic                    busy_r;
  logic [EXT_BITS:0]       trial;

  always_comb begin
    trial = {rem_r, sh_r[MOD_STEPS-1]};
    if (trial >= {1'b0, divisor}) trial = trial - {1'b0, divisor};
    rem_nxt = trial[EXT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == MOD_CNT_BITS'(MOD_STEPS - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[MOD_STEPS-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rem  = rem_r[EXT_BITS-2:0];
  assign done = !busy_r && !start;
endmodule

// ----- rtl/cic_charge_deposit_2d_core.sv -----
// Deposit: locate in ST_MULX, ST_MULY, ST_LOC, ST_PREP (then ST_MOD, the modulo
//   pass, in periodic mode), then ST_NW, ST_NP, ST_NS, ST_NA per node through one
//   shared multiplier. Read: ST_RD, ST_RDW to the output register. Clear: zeroes
//   every word, one word a cycle. After reset the same clearing pass runs; no word
//   is accepted until it ends. Configuration writes are taken on any cycle.
// ----------------------------------------------------------------------------
// cic_charge_deposit_2d_core
// Sequencer, shared multiplier and accumulate path of the CIC deposition core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cic_charge_deposit_2d_core_defines.svh"
module cic_charge_deposit_2d_core
  import ccd2d_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ccd2d_in_if.sink      in_ch,
  ccd2d_out_if.source   out_ch,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MULX = 4'd1;
  localparam logic [3:0] ST_MULY = 4'd2;
  localparam logic [3:0] ST_LOC  = 4'd3;
  localparam logic [3:0] ST_PREP = 4'd4;
  localparam logic [3:0] ST_MOD  = 4'd5;
  localparam logic [3:0] ST_NW   = 4'd6;
  localparam logic [3:0] ST_NP   = 4'd7;
  localparam logic [3:0] ST_NS   = 4'd8;
  localparam logic [3:0] ST_NA   = 4'd9;
  localparam logic [3:0] ST_CLR  = 4'd10;
  localparam logic [3:0] ST_RD   = 4'd11;
  localparam logic [3:0] ST_RDW  = 4'd12;

  // configuration
  logic [EXT_BITS-1:0] nx_r, ny_r;
  logic                per_r;
  logic [23:0]         invx_r, invy_r;
  logic signed [31:0]  scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r    <= EXT_BITS'(64);
      ny_r    <= EXT_BITS'(64);
      per_r   <= 1'b1;
      invx_r  <= 24'd65536;
      invy_r  <= 24'd65536;
      scale_r <= 32'sd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NX:    nx_r    <= cfg_wdata[EXT_BITS-1:0];
        REG_NY:    ny_r    <= cfg_wdata[EXT_BITS-1:0];
        REG_PER:   per_r   <= cfg_wdata[0];
        REG_INVX:  invx_r  <= cfg_wdata[23:0];
        REG_INVY:  invy_r  <= cfg_wdata[23:0];
        REG_SCALE: scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [EXT_BITS-1:0] nx, ny;
  always_comb begin
    nx = nx_r;
    if (nx_r < EXT_BITS'(3)) nx = EXT_BITS'(3);
    else if (nx_r > EXT_BITS'(MAX_NODES_X)) nx = EXT_BITS'(MAX_NODES_X);
    ny = ny_r;
    if (ny_r < EXT_BITS'(3)) ny = EXT_BITS'(3);
    else if (ny_r > EXT_BITS'(MAX_NODES_Y)) ny = EXT_BITS'(MAX_NODES_Y);
  end

  // control and item registers
  logic [3:0]           state_r, state_nxt;
  logic [ADDR_BITS-1:0] clr_cnt_r;
  logic signed [31:0]   posx_r, posy_r;
  logic [ADDR_BITS-1:0] rd_addr_r;
  logic [55:0]          prodx_r, prody_r;
  logic [X_BITS-1:0]    i0_r, i1_r;
  logic [Y_BITS-1:0]    j0_r, j1_r;
  logic [16:0]          fx_r, fy_r;
  logic [1:0]           k_r;
  logic signed [35:0]   share_r;
  logic                 out_valid_r;
  logic signed [31:0]   out_data_r;

  // shared multiplier
  logic signed [33:0]   mul_a, mul_b;
  logic signed [67:0]   mul_r;

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // current node
  logic [X_BITS-1:0] ci;
  logic [Y_BITS-1:0] cj;
  logic [16:0]       wx, wy;
  logic [1:0]        e;
  logic [ADDR_BITS-1:0] node_addr;

  always_comb begin
    ci = k_r[0] ? i1_r : i0_r;
    cj = k_r[1] ? j1_r : j0_r;
    wx = k_r[0] ? fx_r : 17'd65536 - fx_r;
    wy = k_r[1] ? fy_r : 17'd65536 - fy_r;
    e  = 2'd0;
    if (!per_r) begin
      if (ci == '0 || {1'b0, ci} == nx - 1'b1) e = e + 1'b1;
      if (cj == '0 || {1'b0, cj} == ny - 1'b1) e = e + 1'b1;
    end
    node_addr = {cj, ci};
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MULX: begin
        mul_a = 34'(posx_r);
        mul_b = $signed({10'd0, invx_r});
      end
      ST_MULY: begin
        mul_a = 34'(posy_r);
        mul_b = $signed({10'd0, invy_r});
      end
      ST_NW: begin
        mul_a = $signed({17'd0, wx});
        mul_b = $signed({17'd0, wy});
      end
      ST_NP: begin
        mul_a = 34'(scale_r);
        mul_b = $signed(mul_r[33:0]);
      end
      default: ;
    endcase
  end

  // rounding of the share
  logic signed [67:0] rnd;
  logic signed [35:0] share_nxt;
  always_comb begin
    rnd = mul_r;
    share_nxt = '0;
    case (e)
      2'd0: begin
        rnd = mul_r + (68'sd1 <<< 31);
        share_nxt = 36'(rnd >>> 32);
      end
      2'd1: begin
        rnd = mul_r + (68'sd1 <<< 30);
        share_nxt = 36'(rnd >>> 31);
      end
      2'd2: begin
        rnd = mul_r + (68'sd1 <<< 29);
        share_nxt = 36'(rnd >>> 30);
      end
      default: ;
    endcase
  end

  // memory
  ram_req_t    req;
  logic [31:0] rdata;
  logic signed [36:0] sum;
  logic signed [31:0] sat;

  always_comb begin
    sum = 37'($signed(rdata)) + 37'(share_r);
    if (sum > 37'sd2147483647) sat = 32'sh7FFFFFFF;
    else if (sum < -37'sd2147483648) sat = 32'sh80000000;
    else sat = sum[31:0];
  end

  always_comb begin
    req.we    = 1'b0;
    req.waddr = node_addr;
    req.wdata = sat;
    req.raddr = node_addr;
    case (state_r)
      ST_NA: req.we = 1'b1;
      ST_CLR: begin
        req.we    = 1'b1;
        req.waddr = clr_cnt_r;
        req.wdata = '0;
      end
      ST_RD, ST_RDW: req.raddr = rd_addr_r;
      default: ;
    endcase
  end

  ccd2d_grid_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // locate
  logic signed [23:0] gix, giy;
  logic signed [31:0] divx_s, divy_s;
  logic               mod_start;
  logic [X_BITS-1:0]  remx;
  logic [Y_BITS-1:0]  remy;
  logic               donex, doney;

  always_comb begin
    gix = $signed(prodx_r[55:32]);
    giy = $signed(prody_r[55:32]);
    divx_s = 32'(gix) + $signed({1'b0, nx, 24'd0});
    divy_s = 32'(giy) + $signed({1'b0, ny, 24'd0});
    mod_start = (state_r == ST_PREP) && per_r;
  end

  ccd2d_axis_mod u_modx (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (divx_s[MOD_STEPS-1:0]),
    .divisor  (nx),
    .rem      (remx),
    .done     (donex)
  );

  ccd2d_axis_mod u_mody (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (divy_s[MOD_STEPS-1:0]),
    .divisor  (ny),
    .rem      (remy),
    .done     (doney)
  );

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.command)
            CMD_DEPOSIT: if (in_ch.alive) state_nxt = ST_MULX;
            CMD_READ:    state_nxt = ST_RD;
            CMD_CLEAR:   state_nxt = ST_CLR;
            default: ;
          endcase
        end
      end
      ST_MULX: state_nxt = ST_MULY;
      ST_MULY: state_nxt = ST_LOC;
      ST_LOC:  state_nxt = ST_PREP;
      ST_PREP: state_nxt = per_r ? ST_MOD : ST_NW;
      ST_MOD:  if (donex && doney) state_nxt = ST_NW;
      ST_NW:   state_nxt = ST_NP;
      ST_NP:   state_nxt = ST_NS;
      ST_NS:   state_nxt = ST_NA;
      ST_NA:   state_nxt = (k_r == 2'd3) ? ST_IDLE : ST_NW;
      ST_CLR:  if (clr_cnt_r == ADDR_BITS'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_RD:   state_nxt = ST_RDW;
      ST_RDW:  if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == ST_PREP) k_r <= '0;
      if (state_r == ST_NA) k_r <= k_r + 1'b1;
      if (state_r == ST_RDW && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      posx_r    <= in_ch.pos_x;
      posy_r    <= in_ch.pos_y;
      rd_addr_r <= {in_ch.node_y, in_ch.node_x};
    end
    if (state_r == ST_MULY) prodx_r <= mul_r[55:0];
    if (state_r == ST_LOC)  prody_r <= mul_r[55:0];
    if (state_r == ST_PREP && !per_r) begin
      if (gix < 0) begin
        i0_r <= '0;
        fx_r <= '0;
      end else if (gix >= 24'(nx - 1'b1)) begin
        i0_r <= X_BITS'(nx - 2'd2);
        fx_r <= 17'd65536;
      end else begin
        i0_r <= gix[X_BITS-1:0];
        fx_r <= {1'b0, prodx_r[31:16]};
      end
      if (giy < 0) begin
        j0_r <= '0;
        fy_r <= '0;
      end else if (giy >= 24'(ny - 1'b1)) begin
        j0_r <= Y_BITS'(ny - 2'd2);
        fy_r <= 17'd65536;
      end else begin
        j0_r <= giy[Y_BITS-1:0];
        fy_r <= {1'b0, prody_r[31:16]};
      end
    end
    if (state_r == ST_MOD) begin
      i0_r <= remx;
      j0_r <= remy;
      fx_r <= {1'b0, prodx_r[31:16]};
      fy_r <= {1'b0, prody_r[31:16]};
    end
    if (state_r == ST_NS) share_r <= share_nxt;
    if (state_r == ST_RDW && (!out_valid_r || out_ch.ready)) out_data_r <= rdata;
  end

  // upper neighbors, wrapping in periodic mode
  always_comb begin
    i1_r = i0_r + 1'b1;
    j1_r = j0_r + 1'b1;
    if (per_r && {1'b0, i0_r} == nx - 1'b1) i1_r = '0;
    if (per_r && {1'b0, j0_r} == ny - 1'b1) j1_r = '0;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.node_charge = out_data_r;

  `CCD2D_ASSERT_NOW(a_we_state, req.we, state_r == ST_NA || state_r == ST_CLR,
    "grid write outside accumulate or clear")
  `CCD2D_ASSERT_NOW(a_extent, 1'b1,
    nx >= EXT_BITS'(3) && nx <= EXT_BITS'(MAX_NODES_X) && ny >= EXT_BITS'(3),
    "effective extent out of range")
  `CCD2D_ASSERT_NEXT(a_na_next, state_r == ST_NA && k_r != 2'd3, state_r == ST_NW,
    "node loop ended early")
  `CCD2D_ASSERT_NOW(a_mod_done, state_r == ST_NW, donex && doney,
    "node loop started before modulo finished")
endmodule
